// ----- hw/rtl/fmp_pkg.sv -----
// ----------------------------------------------------------------------------
// fmp_pkg: shared types and constants for the Fibonacci modulo-prime unit
// Holds the modulus, the value widths, the multiplier chain types and the
// residue reduction helper.
// ----------------------------------------------------------------------------
package fmp_pkg;

  localparam int unsigned VAL_W      = 30;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned INDEX_BITS = 32;
  localparam int unsigned CELLS      = VAL_W;
  localparam int unsigned BIT_CNT_W  = $clog2(INDEX_BITS);

  localparam logic [VAL_W-1:0] MOD_P  = 30'd1000000007;
  localparam logic [SUM_W-1:0] MOD_1X = 32'd1000000007;
  localparam logic [SUM_W-1:0] MOD_2X = 32'd2000000014;

  // Product tags: which doubling term a product belongs to
  typedef enum logic [1:0] {
    TAG_C   = 2'd0,  // F(k) * (2F(k+1) - F(k))
    TAG_D0  = 2'd1,  // F(k)^2
    TAG_D1  = 2'd2,  // F(k+1)^2
    TAG_NONE = 2'd3
  } tag_t;

  // Request into the multiplier chain
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    tag_t             tag;
  } mul_req_t;

  // Product leaving the chain
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] prod;
    tag_t             tag;
  } mul_rsp_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] acc;
    logic [VAL_W-1:0] xs;
    logic [VAL_W-1:0] y;
    tag_t             tag;
  } cell_t;

  // Reduce a value below 3*M into 0..M-1
  function automatic logic [VAL_W-1:0] mod_red3(logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    if (s >= MOD_2X) begin
      r = s - MOD_2X;
    end else if (s >= MOD_1X) begin
      r = s - MOD_1X;
    end else begin
      r = s;
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/fmp_cell.sv -----
// ----------------------------------------------------------------------------
// fmp_cell: one step of an interleaved modular multiplication
// Takes the top multiplier bit, forms 2*acc + bit*y modulo M and hands the
// partial result and the shifted multiplier to the next cell.
// ----------------------------------------------------------------------------
module fmp_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  fmp_pkg::cell_t cell_in,
  output fmp_pkg::cell_t cell_out
);

  logic                      valid_r;
  logic [fmp_pkg::VAL_W-1:0] acc_r;
  logic [fmp_pkg::VAL_W-1:0] xs_r;
  logic [fmp_pkg::VAL_W-1:0] y_r;
  fmp_pkg::tag_t             tag_r;
  logic [fmp_pkg::SUM_W-1:0] sum;
  logic [fmp_pkg::VAL_W-1:0] acc_nxt;

  // Double the partial result and add y when the multiplier bit is set
  always_comb begin
    sum = {1'b0, cell_in.acc, 1'b0}
        + (cell_in.xs[fmp_pkg::VAL_W-1]
           ? {{(fmp_pkg::SUM_W-fmp_pkg::VAL_W){1'b0}}, cell_in.y}
           : {fmp_pkg::SUM_W{1'b0}});
    acc_nxt = fmp_pkg::mod_red3(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_in.valid;
    end
  end

  // Advance the payload every cycle
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    xs_r  <= {cell_in.xs[fmp_pkg::VAL_W-2:0], 1'b0};
    y_r   <= cell_in.y;
    tag_r <= cell_in.tag;
  end

  assign cell_out.valid = valid_r;
  assign cell_out.acc   = acc_r;
  assign cell_out.xs    = xs_r;
  assign cell_out.y     = y_r;
  assign cell_out.tag   = tag_r;

endmodule

// ----- hw/rtl/fmp_chain.sv -----
// ----------------------------------------------------------------------------
// fmp_chain: pipelined modular multiplier built from a row of cells
// One cell per multiplier bit; accepts a product each cycle and returns it
// modulo M from the last of the CELLS cells.
// ----------------------------------------------------------------------------
module fmp_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  fmp_pkg::mul_req_t req,
  output fmp_pkg::mul_rsp_t rsp
);

  fmp_pkg::cell_t link [fmp_pkg::CELLS+1];

  // Feed the first cell with a cleared partial result
  assign link[0].valid = req.valid;
  assign link[0].acc   = '0;
  assign link[0].xs    = req.x;
  assign link[0].y     = req.y;
  assign link[0].tag   = req.tag;

  for (genvar i = 0; i < fmp_pkg::CELLS; i++) begin : g_cell
    fmp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (link[i]),
      .cell_out (link[i+1])
    );
  end

  assign rsp.valid = link[fmp_pkg::CELLS].valid;
  assign rsp.prod  = link[fmp_pkg::CELLS].acc;
  assign rsp.tag   = link[fmp_pkg::CELLS].tag;

endmodule

// ----- hw/rtl/fibonacci_mod_prime_unit.sv -----
// ----------------------------------------------------------------------------
// fibonacci_mod_prime_unit: Fibonacci term F(n+1) modulo 1000000007
// Fast doubling over the index bits, using a pipelined cell-chain multiplier.
// ----------------------------------------------------------------------------
// For each accepted index n the unit returns F(n+1) mod 1000000007 as one
// item. It walks the 32 index bits from the top down. Each bit issues three
// products into a 30-cell modular multiplier chain, waits in S_WAIT until
// all three products have come back, then combines terms in S_SUM and
// S_UPD. A new index is accepted only in S_IDLE, after the previous result
// has been loaded into the output register. One item is worked on at a
// time; a finished result waits in the output register while the next
// index is taken in.
module fibonacci_mod_prime_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [29:0] fib_value, [31:30] zero
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_WAIT  = 6'b000100,
    S_SUM   = 6'b001000,
    S_UPD   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [fmp_pkg::INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [fmp_pkg::BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic [1:0]                     iss_r, iss_nxt;
  logic [1:0]                     rcv_r, rcv_nxt;
  logic [fmp_pkg::VAL_W-1:0]      fk_r, fk_nxt;
  logic [fmp_pkg::VAL_W-1:0]      fk1_r, fk1_nxt;
  logic [fmp_pkg::VAL_W-1:0]      c_r, d0_r, d1_r, d_r;
  logic [fmp_pkg::VAL_W-1:0]      t_val;
  logic                           out_valid_r, out_valid_nxt;
  logic [fmp_pkg::VAL_W-1:0]      out_val_r;
  logic                           load_out;
  fmp_pkg::mul_req_t              req;
  fmp_pkg::mul_rsp_t              rsp;

  fmp_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Form 2F(k+1) - F(k) modulo M
  assign t_val = fmp_pkg::mod_red3({1'b0, fk1_r, 1'b0} + fmp_pkg::MOD_1X
                                   - {2'b00, fk_r});

  // Issue the three products of one doubling step
  always_comb begin
    req.valid = (state_r == S_ISSUE);
    req.tag   = fmp_pkg::TAG_NONE;
    req.x     = fk_r;
    req.y     = fk_r;
    unique case (iss_r)
      2'd0: begin
        req.tag = fmp_pkg::TAG_C;
        req.y   = t_val;
      end
      2'd1: begin
        req.tag = fmp_pkg::TAG_D0;
      end
      default: begin
        req.tag = fmp_pkg::TAG_D1;
        req.x   = fk1_r;
        req.y   = fk1_r;
      end
    endcase
  end

  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Sequence the doubling steps
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    iss_nxt   = iss_r;
    rcv_nxt   = rsp.valid ? rcv_r + 2'd1 : rcv_r;
    fk_nxt    = fk_r;
    fk1_nxt   = fk1_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          idx_nxt   = in_tdata;
          bit_nxt   = fmp_pkg::BIT_CNT_W'(fmp_pkg::INDEX_BITS - 1);
          iss_nxt   = 2'd0;
          rcv_nxt   = 2'd0;
          fk_nxt    = '0;
          fk1_nxt   = fmp_pkg::VAL_W'(1);
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        iss_nxt = iss_r + 2'd1;
        if (iss_r == 2'd2) begin
          iss_nxt   = 2'd0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rcv_r == 2'd3) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        rcv_nxt = 2'd0;
        if (idx_r[fmp_pkg::INDEX_BITS-1]) begin
          fk_nxt  = d_r;
          fk1_nxt = fmp_pkg::mod_red3({2'b00, c_r} + {2'b00, d_r});
        end else begin
          fk_nxt  = c_r;
          fk1_nxt = d_r;
        end
        idx_nxt = {idx_r[fmp_pkg::INDEX_BITS-2:0], 1'b0};
        if (bit_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= 2'd0;
      rcv_r       <= 2'd0;
      bit_r       <= '0;
      fk_r        <= '0;
      fk1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      rcv_r       <= rcv_nxt;
      bit_r       <= bit_nxt;
      fk_r        <= fk_nxt;
      fk1_r       <= fk1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture products by tag, sum the squares, load the result
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (rsp.valid) begin
      unique case (rsp.tag)
        fmp_pkg::TAG_C:  c_r  <= rsp.prod;
        fmp_pkg::TAG_D0: d0_r <= rsp.prod;
        fmp_pkg::TAG_D1: d1_r <= rsp.prod;
        default:         c_r  <= c_r;
      endcase
    end
    if (state_r == S_SUM) begin
      d_r <= fmp_pkg::mod_red3({2'b00, d0_r} + {2'b00, d1_r});
    end
    if (load_out) begin
      out_val_r <= fk1_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r};

  // Products only come back while waiting on the chain
  a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid |-> (state_r == S_WAIT))
    else $error("product returned outside wait state");

  // Sum only after all three products arrived
  a_sum_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (rcv_r == 2'd3))
    else $error("sum started with missing products");

  // Residues stay reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (fk_r < fmp_pkg::MOD_P) && (fk1_r < fmp_pkg::MOD_P))
    else $error("residue out of range");

  // A new result only comes from the finish state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finish state");

endmodule
